/* hdl/lca_pkg.sv */
// Shared constants for the life cellular automaton block: field widths,
// command codes, register indexes and reset values.
// No dependencies.
`timescale 1ns / 1ps

package lca_pkg;

   // storage defaults for the top-level parameters
   localparam int MAX_WIDTH_DEF  = 256;
   localparam int MAX_HEIGHT_DEF = 128;

   // payload field widths
   localparam int COMMAND_W     = 3;
   localparam int CELL_X_W      = 8;
   localparam int CELL_Y_W      = 7;
   localparam int GRID_WIDTH_W  = 9;
   localparam int GRID_HEIGHT_W = 8;
   localparam int CSR_INDEX_W   = 1;
   localparam int CSR_DATA_W    = 9;

   // register reset values
   localparam logic [GRID_WIDTH_W-1:0]  GRID_WIDTH_RST  = 9'd160;
   localparam logic [GRID_HEIGHT_W-1:0] GRID_HEIGHT_RST = 8'd90;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_GRID_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GRID_HEIGHT = 1'b1;

   // command codes
   localparam logic [COMMAND_W-1:0] CMD_WRITE  = 3'd0;
   localparam logic [COMMAND_W-1:0] CMD_TOGGLE = 3'd1;
   localparam logic [COMMAND_W-1:0] CMD_READ   = 3'd2;
   localparam logic [COMMAND_W-1:0] CMD_STEP   = 3'd3;
   localparam logic [COMMAND_W-1:0] CMD_CLEAR  = 3'd4;

   // B3/S23 rule thresholds on a 4-bit neighbor count
   localparam logic [3:0] LIVE_LOW  = 4'd2;
   localparam logic [3:0] LIVE_HIGH = 4'd3;
   localparam logic [3:0] BIRTH     = 4'd3;

endpackage

/* hdl/life_cellular_automaton.sv */
// Top level of the life cellular automaton: row-wide cell memory, cell
// command pipeline, generation sweep, clearing pass and result queue.
// Depends on lca_pkg.
`timescale 1ns / 1ps
//
//  channel  direction  handshake              payload
//  req      in         req_valid / req_ready  command, cell_x, cell_y, write_value
//  rsp      out        rsp_valid / rsp_ready  cell_value, coord_error
//  csr      in         csr_valid / csr_ready  csr_index, csr_wdata
//
//  Write, toggle and read are taken one per cycle back to back while the result
//  queue has room; a result is registered in the cell stage, then in the queue
//  (row read, then modify and write back of the row). A step holds off input
//  while it reads the used rows, one per cycle through the single read port,
//  then the report read of the addressed row. Clear, and the pass after reset,
//  hold off input while they write every row, one row write per cycle.
//  Input and the report read wait while two results sit in the two-entry result
//  queue and the cell stage together and none leaves in that cycle.

module life_cellular_automaton import lca_pkg::*; #(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [COMMAND_W-1:0]     req_command,
   input  logic [CELL_X_W-1:0]      req_cell_x,
   input  logic [CELL_Y_W-1:0]      req_cell_y,
   input  logic                     req_write_value,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic                     rsp_cell_value,
   output logic                     rsp_coord_error,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_INDEX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]    csr_wdata
);

   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int ROW_W  = $clog2(MAX_HEIGHT);
   localparam int UW_W   = $clog2(MAX_WIDTH + 1);
   localparam int UH_W   = $clog2(MAX_HEIGHT + 1);
   localparam int WCMP_W = (UW_W > GRID_WIDTH_W) ? UW_W : GRID_WIDTH_W;
   localparam int HCMP_W = (UH_W > GRID_HEIGHT_W) ? UH_W : GRID_HEIGHT_W;
   localparam logic [ROW_W-1:0] CLR_LAST = ROW_W'(MAX_HEIGHT - 1);

   localparam logic [1:0] ST_CLEAR  = 2'd0;
   localparam logic [1:0] ST_IDLE   = 2'd1;
   localparam logic [1:0] ST_STEP   = 2'd2;
   localparam logic [1:0] ST_REPORT = 2'd3;

   typedef struct packed {
      logic cell_value;
      logic coord_error;
   } rsp_type;

   typedef logic [MAX_WIDTH-1:0] row_type;

   // cell memory, one row per word
   row_type mem [MAX_HEIGHT];
   row_type rdata_ff;

   logic             mem_we;
   logic [ROW_W-1:0] mem_waddr;
   row_type          mem_wdata;
   logic             mem_re;
   logic [ROW_W-1:0] mem_raddr;

   // configuration
   logic [GRID_WIDTH_W-1:0]  grid_width_ff, grid_width_in;
   logic [GRID_HEIGHT_W-1:0] grid_height_ff, grid_height_in;
   logic [WCMP_W-1:0]        gw_ext, used_w;
   logic [HCMP_W-1:0]        gh_ext, used_h;

   // sequencer
   logic [1:0]        state_ff, state_in;
   logic [ROW_W-1:0]  clr_row_ff, clr_row_in;
   logic              report_ff, report_in;
   logic [HCMP_W-1:0] rd_row_ff, rd_row_in;
   logic              rvalid_ff, rvalid_in;
   logic              have_cur_ff, have_cur_in;
   logic [ROW_W-1:0]  wr_row_ff, wr_row_in;
   row_type           above_ff, above_in;
   row_type           cur_ff, cur_in;
   logic [CELL_X_W-1:0] pend_x_ff, pend_x_in;
   logic [CELL_Y_W-1:0] pend_y_ff, pend_y_in;

   // cell command stage
   logic                 b_valid_ff, b_valid_in;
   logic [COMMAND_W-1:0] b_cmd_ff, b_cmd_in;
   logic [CELL_X_W-1:0]  b_x_ff, b_x_in;
   logic [ROW_W-1:0]     b_row_ff, b_row_in;
   logic                 b_wv_ff, b_wv_in;
   logic                 b_inside_ff, b_inside_in;
   logic                 b_fwd_ff, b_fwd_in;
   row_type              fwd_row_ff, fwd_row_in;

   // result queue
   logic [1:0] cnt_ff, cnt_in;
   rsp_type    slot0_ff, slot0_in;
   rsp_type    slot1_ff, slot1_in;

   logic                 acc, pop, room, inj, issue_b;
   logic [2:0]           occ;
   logic [COMMAND_W-1:0] i_cmd;
   logic [CELL_X_W-1:0]  i_x;
   logic [CELL_Y_W-1:0]  i_y;
   logic                 i_inside;
   logic [ROW_W-1:0]     i_row;
   row_type              b_row_data, b_new_row;
   logic [COL_W-1:0]     b_col;
   logic                 b_we;
   rsp_type              b_rsp;
   logic                 step_issue;
   row_type              col_mask, below, next_row;

   // ---------------------------------------------------------------- config
   assign csr_ready = 1'b1;

   always_comb begin
      grid_width_in  = grid_width_ff;
      grid_height_in = grid_height_ff;
      if (csr_valid) begin
         if (csr_index == CSR_GRID_WIDTH) begin
            grid_width_in = csr_wdata[GRID_WIDTH_W-1:0];
         end else begin
            grid_height_in = csr_wdata[GRID_HEIGHT_W-1:0];
         end
      end
   end

   // clamp the registers to 1..max
   assign gw_ext = WCMP_W'(grid_width_ff);
   assign gh_ext = HCMP_W'(grid_height_ff);

   always_comb begin
      if (gw_ext == '0) begin
         used_w = WCMP_W'(1);
      end else if (gw_ext > WCMP_W'(MAX_WIDTH)) begin
         used_w = WCMP_W'(MAX_WIDTH);
      end else begin
         used_w = gw_ext;
      end
      if (gh_ext == '0) begin
         used_h = HCMP_W'(1);
      end else if (gh_ext > HCMP_W'(MAX_HEIGHT)) begin
         used_h = HCMP_W'(MAX_HEIGHT);
      end else begin
         used_h = gh_ext;
      end
   end

   // ---------------------------------------------------------------- handshakes
   assign pop  = rsp_valid && rsp_ready;
   assign occ  = {1'b0, cnt_ff} + {2'b00, b_valid_ff};
   assign room = (occ <= 3'd1) || ((occ == 3'd2) && pop);
   assign req_ready = (state_ff == ST_IDLE) && room;
   assign acc  = req_valid && req_ready;
   assign inj  = (state_ff == ST_REPORT) && room;

   // a step or clear reports through a read of the addressed cell once done
   assign issue_b = (acc && !(req_command inside {CMD_STEP, CMD_CLEAR})) || inj;
   assign i_cmd   = inj ? CMD_READ : req_command;
   assign i_x     = inj ? pend_x_ff : req_cell_x;
   assign i_y     = inj ? pend_y_ff : req_cell_y;
   assign i_inside = (WCMP_W'(i_x) < used_w) && (HCMP_W'(i_y) < used_h);
   assign i_row   = ROW_W'(i_y);

   // ---------------------------------------------------------------- cell stage
   assign b_row_data = b_fwd_ff ? fwd_row_ff : rdata_ff;
   assign b_col      = COL_W'(b_x_ff);

   always_comb begin
      b_new_row = b_row_data;
      case (b_cmd_ff)
         CMD_WRITE:  b_new_row[b_col] = b_wv_ff;
         CMD_TOGGLE: b_new_row[b_col] = ~b_row_data[b_col];
         default:    b_new_row = b_row_data;
      endcase
   end

   assign b_we = b_valid_ff && b_inside_ff && (b_cmd_ff inside {CMD_WRITE, CMD_TOGGLE});
   assign b_rsp.cell_value  = b_inside_ff & b_new_row[b_col];
   assign b_rsp.coord_error = ~b_inside_ff;

   // forward the row being written to a read of the same row issued this cycle
   assign b_fwd_in   = b_we && (b_row_ff == i_row);
   assign fwd_row_in = b_new_row;
   assign b_valid_in = issue_b;
   assign b_cmd_in   = i_cmd;
   assign b_x_in     = i_x;
   assign b_row_in   = i_row;
   assign b_wv_in    = req_write_value;
   assign b_inside_in = i_inside;

   // ---------------------------------------------------------------- generation
   assign step_issue = (state_ff == ST_STEP) && (rd_row_ff < used_h);
   assign below      = rvalid_ff ? rdata_ff : '0;

   always_comb begin
      for (int i = 0; i < MAX_WIDTH; i++) begin
         col_mask[i] = (WCMP_W'(i) < used_w);
      end
   end

   always_comb begin
      logic [MAX_WIDTH+1:0] ap, cp, bp;
      logic [3:0]           n;
      ap = {1'b0, above_ff & col_mask, 1'b0};
      cp = {1'b0, cur_ff & col_mask, 1'b0};
      bp = {1'b0, below & col_mask, 1'b0};
      for (int i = 0; i < MAX_WIDTH; i++) begin
         n = {3'b000, ap[i]} + {3'b000, ap[i+1]} + {3'b000, ap[i+2]} +
             {3'b000, cp[i]} + {3'b000, cp[i+2]} +
             {3'b000, bp[i]} + {3'b000, bp[i+1]} + {3'b000, bp[i+2]};
         if (!col_mask[i]) begin
            next_row[i] = cur_ff[i];
         end else if (cur_ff[i]) begin
            next_row[i] = (n >= LIVE_LOW) && (n <= LIVE_HIGH);
         end else begin
            next_row[i] = (n == BIRTH);
         end
      end
   end

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      state_in    = state_ff;
      clr_row_in  = clr_row_ff;
      report_in   = report_ff;
      rd_row_in   = rd_row_ff;
      rvalid_in   = rvalid_ff;
      have_cur_in = have_cur_ff;
      wr_row_in   = wr_row_ff;
      above_in    = above_ff;
      cur_in      = cur_ff;
      pend_x_in   = pend_x_ff;
      pend_y_in   = pend_y_ff;
      if (acc) begin
         pend_x_in = req_cell_x;
         pend_y_in = req_cell_y;
      end
      case (state_ff)
         ST_CLEAR: begin
            clr_row_in = clr_row_ff + ROW_W'(1);
            if (clr_row_ff == CLR_LAST) begin
               state_in = report_ff ? ST_REPORT : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (acc && (req_command == CMD_STEP)) begin
               state_in    = ST_STEP;
               rd_row_in   = '0;
               rvalid_in   = 1'b0;
               have_cur_in = 1'b0;
            end else if (acc && (req_command == CMD_CLEAR)) begin
               state_in   = ST_CLEAR;
               clr_row_in = '0;
               report_in  = 1'b1;
            end
         end
         ST_STEP: begin
            if (step_issue) begin
               rd_row_in = rd_row_ff + HCMP_W'(1);
            end
            rvalid_in = step_issue;
            if (rvalid_ff) begin
               // shift the row window down by one
               have_cur_in = 1'b1;
               wr_row_in   = have_cur_ff ? wr_row_ff + ROW_W'(1) : '0;
               above_in    = have_cur_ff ? cur_ff : '0;
               cur_in      = rdata_ff;
            end else if (have_cur_ff) begin
               state_in = ST_REPORT;
            end
         end
         ST_REPORT: begin
            if (room) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------- memory ports
   always_comb begin
      case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_row_ff;
            mem_wdata = '0;
            mem_re    = 1'b0;
            mem_raddr = i_row;
         end
         ST_STEP: begin
            mem_we    = have_cur_ff;
            mem_waddr = wr_row_ff;
            mem_wdata = next_row;
            mem_re    = step_issue;
            mem_raddr = ROW_W'(rd_row_ff);
         end
         default: begin
            mem_we    = b_we;
            mem_waddr = b_row_ff;
            mem_wdata = b_new_row;
            mem_re    = issue_b && i_inside;
            mem_raddr = i_row;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= mem[mem_raddr];
      end
   end

   // ---------------------------------------------------------------- result queue
   always_comb begin
      cnt_in   = cnt_ff;
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      case ({b_valid_ff, pop})
         2'b10: begin
            cnt_in = cnt_ff + 2'd1;
            if (cnt_ff == 2'd0) begin
               slot0_in = b_rsp;
            end else begin
               slot1_in = b_rsp;
            end
         end
         2'b01: begin
            cnt_in   = cnt_ff - 2'd1;
            slot0_in = slot1_ff;
         end
         2'b11: begin
            if (cnt_ff == 2'd1) begin
               slot0_in = b_rsp;
            end else begin
               slot0_in = slot1_ff;
               slot1_in = b_rsp;
            end
         end
         default: cnt_in = cnt_ff;
      endcase
   end

   assign rsp_valid       = (cnt_ff != 2'd0);
   assign rsp_cell_value  = slot0_ff.cell_value;
   assign rsp_coord_error = slot0_ff.coord_error;

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff  <= GRID_WIDTH_RST;
         grid_height_ff <= GRID_HEIGHT_RST;
         state_ff       <= ST_CLEAR;
         clr_row_ff     <= '0;
         report_ff      <= 1'b0;
         rvalid_ff      <= 1'b0;
         have_cur_ff    <= 1'b0;
         b_valid_ff     <= 1'b0;
         cnt_ff         <= 2'd0;
      end else begin
         grid_width_ff  <= grid_width_in;
         grid_height_ff <= grid_height_in;
         state_ff       <= state_in;
         clr_row_ff     <= clr_row_in;
         report_ff      <= report_in;
         rvalid_ff      <= rvalid_in;
         have_cur_ff    <= have_cur_in;
         b_valid_ff     <= b_valid_in;
         cnt_ff         <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_row_ff   <= rd_row_in;
      wr_row_ff   <= wr_row_in;
      above_ff    <= above_in;
      cur_ff      <= cur_in;
      pend_x_ff   <= pend_x_in;
      pend_y_ff   <= pend_y_in;
      b_cmd_ff    <= b_cmd_in;
      b_x_ff      <= b_x_in;
      b_row_ff    <= b_row_in;
      b_wv_ff     <= b_wv_in;
      b_inside_ff <= b_inside_in;
      b_fwd_ff    <= b_fwd_in;
      fwd_row_ff  <= fwd_row_in;
      slot0_ff    <= slot0_in;
      slot1_ff    <= slot1_in;
   end

endmodule

/* hdl/lca_checker.sv */
// Port-level checks for the life cellular automaton, attached by bind.
// Depends on lca_pkg and life_cellular_automaton.
`timescale 1ns / 1ps

module lca_checker import lca_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic [COMMAND_W-1:0] req_command,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic                 rsp_cell_value,
   input logic                 rsp_coord_error,
   input logic                 csr_ready
);

   // the clearing pass holds off input right after reset
   a_reset_clears : assert property (@(posedge clock)
      (!reset && $past(reset)) |-> !req_ready)
      else $error("input ready during the clearing pass after reset");

   // a step or clear transfer starts a sweep that blocks input
   a_sweep_blocks : assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && ((req_command == CMD_STEP) || (req_command == CMD_CLEAR)))
      |=> !req_ready)
      else $error("input ready in the cycle after a step or clear transfer");

   // an out-of-grid result never reports a live cell
   a_error_dead : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_coord_error) |-> !rsp_cell_value)
      else $error("coordinate error reported with a live cell");

   // hold a stalled result
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
      (rsp_valid && $stable(rsp_cell_value) && $stable(rsp_coord_error)))
      else $error("result changed or dropped while stalled");

   // configuration writes are never refused while a result is valid
   a_csr_ready : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> csr_ready)
      else $error("configuration port not ready");

endmodule

bind life_cellular_automaton lca_checker u_lca_checker (.*);

/* verif/tb_top.sv */
// Testbench for life_cellular_automaton: drives cell commands and grid size
// writes, predicts each result from a board model of its own and checks it.
// Depends on lca_pkg and the life_cellular_automaton RTL.
`timescale 1ns / 1ps

module tb_top;
   import lca_pkg::*;

   localparam int ITEMS_PER_PHASE = 110;
   localparam int SIZE_PHASES     = 14;
   localparam int BOARD_CELLS     = MAX_WIDTH_DEF * MAX_HEIGHT_DEF;
   localparam int X_TOP           = (1 << CELL_X_W) - 1;
   localparam int Y_TOP           = (1 << CELL_Y_W) - 1;
   localparam logic [COMMAND_W-1:0] CMD_SPARE_LO = CMD_CLEAR + 3'd1;
   localparam logic [COMMAND_W-1:0] CMD_SPARE_HI = {COMMAND_W{1'b1}};

   typedef struct packed {
      logic [COMMAND_W-1:0] command;
      logic [CELL_X_W-1:0]  cell_x;
      logic [CELL_Y_W-1:0]  cell_y;
      logic                 write_value;
   } cell_cmd_type;

   typedef struct packed {
      logic cell_value;
      logic coord_error;
   } cell_result_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [COMMAND_W-1:0]   req_command = '0;
   logic [CELL_X_W-1:0]    req_cell_x = '0;
   logic [CELL_Y_W-1:0]    req_cell_y = '0;
   logic                   req_write_value = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic                   rsp_cell_value;
   logic                   rsp_coord_error;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   life_cellular_automaton u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_command     (req_command),
      .req_cell_x      (req_cell_x),
      .req_cell_y      (req_cell_y),
      .req_write_value (req_write_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_cell_value  (rsp_cell_value),
      .rsp_coord_error (rsp_coord_error),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #6 clock = ~clock;

   // board model and its grid size registers
   bit                       cell_board [BOARD_CELLS];
   bit                       board_snap [BOARD_CELLS];
   logic [GRID_WIDTH_W-1:0]  grid_cols = GRID_WIDTH_RST;
   logic [GRID_HEIGHT_W-1:0] grid_rows = GRID_HEIGHT_RST;

   cell_cmd_type    pending_cmds [$];
   cell_result_type cell_results_q [$];
   int              queued_cmds;
   int              mismatches;
   int              rsp_count;
   int              burst_left = 1;
   int              gap_left;
   int              rsp_tick;
   int              stall_mode;

   function automatic int used_cols();
      if (grid_cols == 0) return 1;
      if (grid_cols > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
      return int'(grid_cols);
   endfunction

   function automatic int used_rows();
      if (grid_rows == 0) return 1;
      if (grid_rows > MAX_HEIGHT_DEF) return MAX_HEIGHT_DEF;
      return int'(grid_rows);
   endfunction

   // B3/S23 over the grid in use, all cells at once; neighbors off the grid are dead
   function automatic void advance_board();
      int w, h, n, xx, yy, at;
      w = used_cols();
      h = used_rows();
      for (int y = 0; y < h; y++)
         for (int x = 0; x < w; x++)
            board_snap[y * MAX_WIDTH_DEF + x] = cell_board[y * MAX_WIDTH_DEF + x];
      for (int y = 0; y < h; y++) begin
         for (int x = 0; x < w; x++) begin
            n = 0;
            for (int dy = -1; dy <= 1; dy++) begin
               for (int dx = -1; dx <= 1; dx++) begin
                  yy = y + dy;
                  xx = x + dx;
                  if ((dx != 0 || dy != 0) && yy >= 0 && yy < h && xx >= 0 && xx < w)
                     n += int'(board_snap[yy * MAX_WIDTH_DEF + xx]);
               end
            end
            at = y * MAX_WIDTH_DEF + x;
            if (board_snap[at])
               cell_board[at] = (n >= LIVE_LOW && n <= LIVE_HIGH);
            else
               cell_board[at] = (n == BIRTH);
         end
      end
   endfunction

   function automatic cell_result_type predict_command(logic [COMMAND_W-1:0] cmd,
                                                       logic [CELL_X_W-1:0] x,
                                                       logic [CELL_Y_W-1:0] y,
                                                       logic wv);
      cell_result_type res;
      bit in_grid;
      int at;
      in_grid = (x < used_cols()) && (y < used_rows());
      at = y * MAX_WIDTH_DEF + x;
      case (cmd)
         CMD_STEP:   advance_board();
         CMD_CLEAR:  foreach (cell_board[i]) cell_board[i] = 1'b0;
         CMD_WRITE:  if (in_grid) cell_board[at] = wv;
         CMD_TOGGLE: if (in_grid) cell_board[at] = !cell_board[at];
         default: ;
      endcase
      res.cell_value  = in_grid ? cell_board[at] : 1'b0;
      res.coord_error = !in_grid;
      return res;
   endfunction

   task automatic log_failure(string what);
      mismatches++;
      if (mismatches <= 10)
         $display("%0t: %s", $time, what);
   endtask

   task automatic queue_cmd(logic [COMMAND_W-1:0] c, int x, int y, logic wv);
      cell_cmd_type it;
      it.command     = c;
      it.cell_x      = CELL_X_W'(x);
      it.cell_y      = CELL_Y_W'(y);
      it.write_value = wv;
      pending_cmds = {pending_cmds, it};
      queued_cmds++;
   endtask

   // seed a 3x3 patch, let it evolve, then look at it
   task automatic queue_pattern(int w, int h, bit heavy);
      int ox, oy, steps;
      ox = $urandom_range(0, (w > 3) ? w - 3 : 0);
      oy = $urandom_range(0, (h > 3) ? h - 3 : 0);
      for (int dy = 0; dy < 3; dy++)
         for (int dx = 0; dx < 3; dx++)
            queue_cmd(($urandom_range(0, 4) == 0) ? CMD_TOGGLE : CMD_WRITE,
                      ox + dx, oy + dy, $urandom_range(0, 2) != 0);
      steps = heavy ? 1 : $urandom_range(1, 3);
      repeat (steps)
         queue_cmd(CMD_STEP, ox + $urandom_range(0, 2), oy + $urandom_range(0, 2),
                   $urandom_range(0, 1) != 0);
      repeat (3)
         queue_cmd(CMD_READ, ox + $urandom_range(0, 2), oy + $urandom_range(0, 2),
                   $urandom_range(0, 1) != 0);
   endtask

   task automatic queue_noise(int w, int h, bit heavy);
      int r, x, y;
      logic [COMMAND_W-1:0] c;
      r = $urandom_range(0, 99);
      if (r < 25) c = CMD_WRITE;
      else if (r < 45) c = CMD_TOGGLE;
      else if (r < 72) c = CMD_READ;
      else if (r < 84) c = heavy ? CMD_READ : CMD_STEP;
      else if (r < 87) c = CMD_CLEAR;
      else if (r < 93) c = COMMAND_W'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
      else c = CMD_READ;
      if ($urandom_range(0, 4) == 0) begin
         x = $urandom_range(0, X_TOP);
         y = $urandom_range(0, Y_TOP);
      end else begin
         x = $urandom_range(0, w - 1);
         y = $urandom_range(0, h - 1);
      end
      queue_cmd(c, x, y, $urandom_range(0, 1) != 0);
   endtask

   task automatic write_register(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_GRID_WIDTH)
         grid_cols = data;
      else
         grid_rows = data[GRID_HEIGHT_W-1:0];
      csr_valid <= 1'b0;
   endtask

   task automatic wait_idle();
      do @(posedge clock);
      while (pending_cmds.size() != 0 || req_valid || cell_results_q.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   // sender: bursts of transfers separated by random gaps
   always @(posedge clock) begin : drive_proc
      cell_cmd_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            cell_results_q = {cell_results_q,
                              predict_command(req_command, req_cell_x, req_cell_y,
                                              req_write_value)};
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_cmds.size() > 0) begin
               nxt = pending_cmds.pop_front();
               req_valid       <= 1'b1;
               req_command     <= nxt.command;
               req_cell_x      <= nxt.cell_x;
               req_cell_y      <= nxt.cell_y;
               req_write_value <= nxt.write_value;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 24);
                  gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver: check each transfer, stall on one of four patterns picked at random
   always @(posedge clock) begin : check_proc
      cell_result_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (cell_results_q.size() == 0) begin
               log_failure($sformatf("result %0d arrived with none outstanding", rsp_count));
            end else begin
               want = cell_results_q.pop_front();
               if (rsp_cell_value !== want.cell_value || rsp_coord_error !== want.coord_error)
                  log_failure($sformatf(
                     "result %0d: cell_value exp %0b got %0b, coord_error exp %0b got %0b",
                     rsp_count, want.cell_value, rsp_cell_value,
                     want.coord_error, rsp_coord_error));
            end
            rsp_count++;
         end
         rsp_tick++;
         if (rsp_tick % 200 == 0)
            stall_mode = $urandom_range(0, 3);
         case (stall_mode)
            0:       rsp_ready <= 1'b1;
            1:       rsp_ready <= ($urandom_range(0, 3) != 0);
            2:       rsp_ready <= (rsp_tick % 3 != 0);
            default: rsp_ready <= ((rsp_tick / 16) % 2 == 0);
         endcase
      end
   end

   initial begin : stim_proc
      int cols, rows;
      bit heavy;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // corner birth with no wrap to the far side
      queue_cmd(CMD_WRITE, 0, 0, 1'b1);
      queue_cmd(CMD_WRITE, 1, 0, 1'b1);
      queue_cmd(CMD_WRITE, 0, 1, 1'b1);
      queue_cmd(CMD_READ, 1, 1, 1'b0);
      queue_cmd(CMD_STEP, 1, 1, 1'b0);
      // blinker on the right edge: nothing may appear in column 0
      queue_cmd(CMD_WRITE, 159, 20, 1'b1);
      queue_cmd(CMD_WRITE, 159, 21, 1'b1);
      queue_cmd(CMD_WRITE, 159, 22, 1'b1);
      queue_cmd(CMD_STEP, 158, 21, 1'b0);
      queue_cmd(CMD_READ, 0, 21, 1'b0);
      queue_cmd(CMD_READ, 159, 20, 1'b0);
      queue_cmd(CMD_TOGGLE, 159, 89, 1'b0);
      queue_cmd(CMD_TOGGLE, 159, 89, 1'b1);
      // addresses just past and far past the grid
      queue_cmd(CMD_WRITE, 160, 0, 1'b1);
      queue_cmd(CMD_WRITE, 0, 90, 1'b1);
      queue_cmd(CMD_TOGGLE, X_TOP, Y_TOP, 1'b0);
      queue_cmd(CMD_READ, X_TOP, Y_TOP, 1'b1);
      queue_cmd(CMD_WRITE, 5, 5, 1'b0);
      queue_cmd(CMD_SPARE_LO, 0, 0, 1'b1);
      queue_cmd(CMD_SPARE_HI, 1, 1, 1'b1);
      queue_cmd(CMD_STEP, 200, 100, 1'b0);
      queue_cmd(CMD_CLEAR, 1, 1, 1'b0);
      queue_cmd(CMD_READ, 0, 0, 1'b0);

      for (int p = 0; p < SIZE_PHASES; p++) begin
         case (p)
            0: begin cols = 1;      rows = 1;      end
            1: begin cols = 256;    rows = 128;    end
            2: begin cols = 0;      rows = 'h100;  end // both read back as zero, used as one
            3: begin cols = 'h1FF;  rows = 'h1FF;  end // clamp to the store size
            4: begin cols = 3;      rows = 3;      end
            5: begin cols = $urandom_range(1, 256); rows = $urandom_range(1, 128); end
            default: begin cols = $urandom_range(1, 24); rows = $urandom_range(1, 20); end
         endcase
         wait_idle();
         if ($urandom_range(0, 1)) begin
            write_register(CSR_GRID_WIDTH, CSR_DATA_W'(cols));
            write_register(CSR_GRID_HEIGHT, CSR_DATA_W'(rows));
         end else begin
            write_register(CSR_GRID_HEIGHT, CSR_DATA_W'(rows));
            write_register(CSR_GRID_WIDTH, CSR_DATA_W'(cols));
         end
         heavy = used_cols() * used_rows() > 4096;
         queued_cmds = 0;
         while (queued_cmds < ITEMS_PER_PHASE) begin
            if ($urandom_range(0, 9) < 6)
               queue_pattern(used_cols(), used_rows(), heavy);
            else
               queue_noise(used_cols(), used_rows(), heavy);
         end
      end

      wait_idle();
      repeat (MAX_HEIGHT_DEF + 8) @(posedge clock);
      if (mismatches == 0 && cell_results_q.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   initial begin
      #20_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule
